// File: rtl/tofs_pkg.sv
package tofs_pkg;

    localparam int MAX_STEPS_DEF   = 32;
    localparam int MAX_DEVICES_DEF = 8;
    localparam int OUTPUTS_DEF     = 8;

    // Input item modes
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_CLEAR  = 3'd1;
    localparam logic [2:0] MODE_APPEND = 3'd2;
    localparam logic [2:0] MODE_FIRE   = 3'd3;
    localparam logic [2:0] MODE_ABORT  = 3'd4;
    localparam logic [2:0] MODE_ADDR   = 3'd5;
    localparam logic [2:0] MODE_SAFETY = 3'd6;
    localparam logic [2:0] MODE_CMD    = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_COIL   = 2'd1;
    localparam logic [1:0] KIND_REG    = 2'd2;
    localparam logic [1:0] KIND_REFUSE = 2'd3;

    // Refusal codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_LOW   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_DEV_COUNT = 3'd0;
    localparam logic [2:0] CFG_COIL_BASE = 3'd1;
    localparam logic [2:0] CFG_SAFETY    = 3'd2;
    localparam logic [2:0] CFG_ENTER     = 3'd3;
    localparam logic [2:0] CFG_EXIT      = 3'd4;

endpackage

// File: rtl/timed_output_fire_sequencer_core.sv
// Channel | Direction | Handshake                 | Content
// cmd     | in        | i_start & !o_busy         | mode and step, slot, report fields
// cfg     | in        | i_cfg_valid & o_cfg_ready | register index and data
// result  | out       | o_valid strobe            | one write, status or refusal item
// Busy spans the whole item: a fire checks one slot at a time, and abort and mode
// commands give one result at a time (up to 64 for an abort). A tick walks its due
// steps twice: the first pass advances over them, the second emits their writes.
// Reset is synchronous and active low; the step table itself is not cleared.
// The receiver cannot stall: every result is shown for exactly one cycle.
module timed_output_fire_sequencer_core #(
    parameter int MAX_STEPS          = tofs_pkg::MAX_STEPS_DEF,
    parameter int MAX_DEVICES        = tofs_pkg::MAX_DEVICES_DEF,
    parameter int OUTPUTS_PER_DEVICE = tofs_pkg::OUTPUTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_device_index,
    input  logic [7:0]  i_output_number,
    input  logic [15:0] i_wait_ms,
    input  logic [7:0]  i_device_addr,
    input  logic [15:0] i_safety_mv,
    input  logic        i_enter_flag,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_bus_addr,
    output logic [15:0] o_target,
    output logic [15:0] o_value,
    output logic [1:0]  o_error_code,
    output logic [2:0]  o_blocked_device,
    output logic        o_running,
    output logic [5:0]  o_step_index,
    output logic [5:0]  o_seq_length,
    output logic        o_last
);

    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int DW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int OW = (OUTPUTS_PER_DEVICE > 1) ? $clog2(OUTPUTS_PER_DEVICE) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_TREAD = 3'd2;
    localparam logic [2:0] S_TEVAL = 3'd3;
    localparam logic [2:0] S_ABORT = 3'd4;
    localparam logic [2:0] S_CMD   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_dev_count;
    logic [15:0] r_coil_base, r_safety_min, r_enter, r_exit;
    logic [7:0]  r_addr [MAX_DEVICES];
    logic [15:0] r_level [MAX_DEVICES];
    logic [CW-1:0] r_stored, r_next;
    logic        r_playing;
    logic [15:0] r_elapsed;
    logic [3:0]  r_dev;
    logic [OW-1:0] r_out;
    logic        r_enter_sel;
    logic [3:0]  r_ndev;
    logic        r_pass2;
    logic [CW-1:0] r_walk;
    logic        r_pend;
    logic [7:0]  r_pend_addr;
    logic [15:0] r_pend_target;

    logic        mem_we;
    logic [22:0] mem_wdata, mem_rdata;
    logic [AW-1:0] mem_raddr;

    logic [2:0]  step_dev;
    logic [7:0]  step_outn;
    logic [15:0] step_delay;
    logic [3:0]  in_ndev;
    logic        accept;
    logic [7:0]  app_outn;
    logic [2:0]  app_dev;

    assign accept      = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;
    assign in_ndev     = (r_dev_count > 4'(MAX_DEVICES)) ? 4'(MAX_DEVICES) : r_dev_count;

    assign step_dev   = mem_rdata[22:20];
    assign step_outn  = {4'd0, mem_rdata[19:16]};
    assign step_delay = mem_rdata[15:0];

    // Clamp an appended step.
    always_comb begin
        app_outn = i_output_number;
        if (i_output_number < 8'd1 || i_output_number > 8'(OUTPUTS_PER_DEVICE)) begin
            app_outn = 8'd1;
        end
        app_dev = i_device_index[2:0];
        if ({4'd0, r_dev_count} <= i_device_index) begin
            app_dev = 3'd0;
        end
    end

    assign mem_we    = accept && (i_mode == tofs_pkg::MODE_APPEND)
                       && (r_stored < CW'(MAX_STEPS));
    assign mem_wdata = {app_dev, app_outn[3:0], i_wait_ms};
    // The first pass of a tick reads at the next step, the second at the walk pointer.
    assign mem_raddr = r_pass2 ? r_walk[AW-1:0] : r_next[AW-1:0];

    tofs_step_mem #(.DEPTH(MAX_STEPS), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_stored[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Main sequencer: one slot or output per cycle; a step takes a read state and an evaluate state.
    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        o_last  <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dev_count <= 4'd0;
            r_coil_base <= 16'd0;
            r_safety_min <= 16'd0;
            r_enter     <= 16'd0;
            r_exit      <= 16'd0;
            r_stored    <= '0;
            r_next      <= '0;
            r_playing   <= 1'b0;
            r_elapsed   <= 16'd0;
            r_pass2     <= 1'b0;
            r_pend      <= 1'b0;
            for (int k = 0; k < MAX_DEVICES; k++) begin
                r_addr[k]  <= 8'd0;
                r_level[k] <= 16'd0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tofs_pkg::CFG_DEV_COUNT: r_dev_count  <= i_cfg_data[3:0];
                    tofs_pkg::CFG_COIL_BASE: r_coil_base  <= i_cfg_data;
                    tofs_pkg::CFG_SAFETY:    r_safety_min <= i_cfg_data;
                    tofs_pkg::CFG_ENTER:     r_enter      <= i_cfg_data;
                    tofs_pkg::CFG_EXIT:      r_exit       <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_dev       <= 4'd0;
                        r_out       <= '0;
                        r_pend      <= 1'b0;
                        r_pass2     <= 1'b0;
                        r_walk      <= r_next;
                        r_ndev      <= in_ndev;
                        r_enter_sel <= i_enter_flag;
                        case (i_mode)
                            tofs_pkg::MODE_TICK: begin
                                if (r_playing && r_stored != '0 && r_elapsed != 16'hFFFF) begin
                                    r_elapsed <= r_elapsed + 16'd1;
                                end
                            end
                            tofs_pkg::MODE_CLEAR: begin
                                r_playing <= 1'b0;
                                r_stored  <= '0;
                                r_next    <= '0;
                            end
                            tofs_pkg::MODE_APPEND: begin
                                if (mem_we) r_stored <= r_stored + CW'(1);
                            end
                            tofs_pkg::MODE_ABORT: r_playing <= 1'b0;
                            tofs_pkg::MODE_ADDR: begin
                                if (i_device_index < 8'(MAX_DEVICES)) begin
                                    r_addr[i_device_index[DW-1:0]] <= i_device_addr;
                                end
                            end
                            tofs_pkg::MODE_SAFETY: begin
                                if (i_device_index < 8'(MAX_DEVICES)) begin
                                    r_level[i_device_index[DW-1:0]] <= i_safety_mv;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_stored == '0) begin
                        o_valid <= 1'b1; o_last <= 1'b1;
                        o_kind <= tofs_pkg::KIND_REFUSE; o_error_code <= tofs_pkg::ERR_EMPTY;
                        o_blocked_device <= 3'd0;
                        o_bus_addr <= 8'd0; o_target <= 16'd0; o_value <= 16'd0;
                    end else if (r_dev >= r_ndev) begin
                        r_next    <= '0;
                        r_elapsed <= 16'd0;
                        r_playing <= 1'b1;
                    end else if (r_level[r_dev[DW-1:0]] < r_safety_min) begin
                        o_valid <= 1'b1; o_last <= 1'b1;
                        o_kind <= tofs_pkg::KIND_REFUSE; o_error_code <= tofs_pkg::ERR_LOW;
                        o_blocked_device <= r_dev[2:0];
                        o_bus_addr <= 8'd0; o_target <= 16'd0; o_value <= 16'd0;
                    end else begin
                        r_dev <= r_dev + 4'd1;
                    end
                end
                S_TREAD: begin
                    // The first pass ends at the end of the table.
                    if (!r_pass2 && !(r_next < r_stored && r_next < CW'(MAX_STEPS))) begin
                        r_pass2 <= 1'b1;
                    end
                end
                S_TEVAL: begin
                    if (!r_pass2) begin
                        // First pass: advance over due steps and settle the state.
                        if (r_elapsed >= step_delay) begin
                            r_elapsed <= 16'd0;
                            r_next <= r_next + CW'(1);
                            if (r_next + CW'(1) >= r_stored) r_playing <= 1'b0;
                        end else begin
                            r_pass2 <= 1'b1;
                        end
                    end else begin
                        // Second pass: one write is held back so the final one can be flagged.
                        if ({1'b0, step_dev} < r_ndev) begin
                            if (r_pend) begin
                                o_valid <= 1'b1;
                                o_kind <= tofs_pkg::KIND_COIL;
                                o_bus_addr <= r_pend_addr;
                                o_target <= r_pend_target;
                                o_value <= 16'd1;
                                o_error_code <= tofs_pkg::ERR_NONE;
                                o_blocked_device <= 3'd0;
                            end
                            r_pend <= 1'b1;
                            r_pend_addr <= r_addr[step_dev[DW-1:0]];
                            r_pend_target <= r_coil_base + {8'd0, step_outn} - 16'd1;
                        end
                        r_walk <= r_walk + CW'(1);
                    end
                end
                S_ABORT: begin
                    o_valid <= 1'b1;
                    o_kind <= tofs_pkg::KIND_COIL;
                    o_bus_addr <= r_addr[r_dev[DW-1:0]];
                    o_target <= r_coil_base + 16'(r_out);
                    o_value <= 16'd0;
                    o_error_code <= tofs_pkg::ERR_NONE;
                    o_blocked_device <= 3'd0;
                    o_last <= (r_out == OW'(OUTPUTS_PER_DEVICE - 1)) && (r_dev + 4'd1 == r_ndev);
                    if (r_out == OW'(OUTPUTS_PER_DEVICE - 1)) begin
                        r_out <= '0;
                        r_dev <= r_dev + 4'd1;
                    end else begin
                        r_out <= r_out + OW'(1);
                    end
                end
                S_CMD: begin
                    o_valid <= 1'b1;
                    o_kind <= tofs_pkg::KIND_REG;
                    o_bus_addr <= r_addr[r_dev[DW-1:0]];
                    o_target <= 16'd0;
                    o_value <= r_enter_sel ? r_enter : r_exit;
                    o_error_code <= tofs_pkg::ERR_NONE;
                    o_blocked_device <= 3'd0;
                    o_last <= (r_dev + 4'd1 == r_ndev);
                    r_dev <= r_dev + 4'd1;
                end
                S_DONE: begin
                    o_valid <= 1'b1; o_last <= 1'b1;
                    o_error_code <= tofs_pkg::ERR_NONE;
                    o_blocked_device <= 3'd0;
                    if (r_pend) begin
                        o_kind <= tofs_pkg::KIND_COIL;
                        o_bus_addr <= r_pend_addr; o_target <= r_pend_target;
                        o_value <= 16'd1;
                        r_pend <= 1'b0;
                    end else begin
                        o_kind <= tofs_pkg::KIND_STATUS;
                        o_bus_addr <= 8'd0; o_target <= 16'd0; o_value <= 16'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Status fields reflect the state after the item; updates land with the result.
    assign o_running    = r_playing;
    assign o_step_index = 6'(r_next);
    assign o_seq_length = 6'(r_stored);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        tofs_pkg::MODE_TICK:
                            n_state = (r_playing && r_stored != '0) ? S_TREAD : S_DONE;
                        tofs_pkg::MODE_FIRE:  n_state = S_SCAN;
                        tofs_pkg::MODE_ABORT: n_state = (in_ndev != 4'd0) ? S_ABORT : S_DONE;
                        tofs_pkg::MODE_CMD:   n_state = (in_ndev != 4'd0) ? S_CMD : S_DONE;
                        default:              n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_stored == '0 || (r_dev < r_ndev && r_level[r_dev[DW-1:0]] < r_safety_min))
                    n_state = S_IDLE;
                else if (r_dev >= r_ndev)
                    n_state = S_DONE;
            end
            S_TREAD: begin
                if (!r_pass2)
                    n_state = (r_next < r_stored && r_next < CW'(MAX_STEPS)) ? S_TEVAL : S_TREAD;
                else
                    n_state = (r_walk < r_next) ? S_TEVAL : S_DONE;
            end
            S_TEVAL: n_state = S_TREAD;
            S_ABORT: begin
                if (r_out == OW'(OUTPUTS_PER_DEVICE - 1) && r_dev + 4'd1 == r_ndev)
                    n_state = S_IDLE;
            end
            S_CMD:  if (r_dev + 4'd1 == r_ndev) n_state = S_IDLE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) != S_IDLE) else $error("result while idle");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy) else $error("not busy after accept");
    a_next_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= r_stored) else $error("next step beyond stored steps");
    a_walk_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEVAL && r_pass2) |-> r_walk < r_next)
        else $error("write pass beyond the fired steps");
`endif

endmodule

// File: rtl/tofs_step_mem.sv
// Step table storage: one write port, one registered read port.
module tofs_step_mem #(
    parameter int DEPTH = tofs_pkg::MAX_STEPS_DEF,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [22:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [22:0]   o_rdata
);

    logic [22:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: bench/tb_timed_output_fire_sequencer_core.sv
module tb_timed_output_fire_sequencer_core;

    localparam int STEPS_CAP   = 32;
    localparam int DEVICES_CAP = 8;
    localparam int OUTPUTS_CAP = 8;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  device_index;
        logic [7:0]  output_number;
        logic [15:0] wait_ms;
        logic [7:0]  device_addr;
        logic [15:0] safety_mv;
        logic        enter_flag;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  bus_addr;
        logic [15:0] target;
        logic [15:0] value;
        logic [1:0]  error_code;
        logic [2:0]  blocked_device;
        logic        running;
        logic [5:0]  step_index;
        logic [5:0]  seq_length;
        logic        last;
    } fire_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [2:0]  i_mode;
    logic [7:0]  i_device_index;
    logic [7:0]  i_output_number;
    logic [15:0] i_wait_ms;
    logic [7:0]  i_device_addr;
    logic [15:0] i_safety_mv;
    logic        i_enter_flag;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_bus_addr;
    logic [15:0] o_target;
    logic [15:0] o_value;
    logic [1:0]  o_error_code;
    logic [2:0]  o_blocked_device;
    logic        o_running;
    logic [5:0]  o_step_index;
    logic [5:0]  o_seq_length;
    logic        o_last;

    timed_output_fire_sequencer_core dut (.*);

    // Shadow copy of the sequencer state and its registers.
    logic [2:0]  tbl_dev [STEPS_CAP];
    logic [7:0]  tbl_out [STEPS_CAP];
    logic [15:0] tbl_delay [STEPS_CAP];
    logic [7:0]  slot_addr [DEVICES_CAP];
    logic [15:0] slot_mv [DEVICES_CAP];
    int          steps_held;
    int          step_next;
    logic        is_playing;
    logic [15:0] ms_count;
    logic [3:0]  reg_dev_count;
    logic [15:0] reg_coil_base;
    logic [15:0] reg_safety_min;
    logic [15:0] reg_enter;
    logic [15:0] reg_exit;

    cmd_item_t    pending_cmds[$];
    fire_result_t expected_writes[$];
    int           errors;
    int           idle_cycles;
    bit           cfg_req;
    logic [2:0]   cfg_idx_req;
    logic [15:0]  cfg_data_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int in_use_count();
        return (reg_dev_count > DEVICES_CAP) ? DEVICES_CAP : int'(reg_dev_count);
    endfunction

    function automatic fire_result_t make_result(logic [1:0] k, logic [7:0] a,
            logic [15:0] t, logic [15:0] v, logic [1:0] e, logic [2:0] b);
        fire_result_t r;
        r = '0;
        r.kind = k;
        r.bus_addr = a;
        r.target = t;
        r.value = v;
        r.error_code = e;
        r.blocked_device = b;
        return r;
    endfunction

    // Work out the results of one accepted item and update the shadow state.
    task automatic predict_fire_results(input cmd_item_t c);
        fire_result_t res[$];
        int ndev;
        int i;
        int j;
        logic [7:0] outn;
        logic [7:0] dix;
        ndev = in_use_count();
        case (c.mode)
            tofs_pkg::MODE_TICK: begin
                if (is_playing && steps_held > 0) begin
                    if (ms_count != 16'hFFFF) ms_count = ms_count + 16'd1;
                    while (step_next < steps_held && step_next < STEPS_CAP) begin
                        if (ms_count < tbl_delay[step_next]) break;
                        if (tbl_dev[step_next] < ndev)
                            res.push_back(make_result(tofs_pkg::KIND_COIL,
                                slot_addr[tbl_dev[step_next]],
                                reg_coil_base + 16'(tbl_out[step_next]) - 16'd1,
                                16'd1, tofs_pkg::ERR_NONE, 3'd0));
                        ms_count = '0;
                        step_next++;
                    end
                    if (step_next >= steps_held) is_playing = 1'b0;
                end
            end
            tofs_pkg::MODE_CLEAR: begin
                is_playing = 1'b0;
                steps_held = 0;
                step_next = 0;
            end
            tofs_pkg::MODE_APPEND: begin
                if (steps_held < STEPS_CAP) begin
                    outn = c.output_number;
                    dix = c.device_index;
                    if (outn < 1 || outn > OUTPUTS_CAP) outn = 8'd1;
                    if (dix >= reg_dev_count) dix = 8'd0;
                    tbl_dev[steps_held] = dix[2:0];
                    tbl_out[steps_held] = outn;
                    tbl_delay[steps_held] = c.wait_ms;
                    steps_held++;
                end
            end
            tofs_pkg::MODE_FIRE: begin
                if (steps_held == 0) begin
                    res.push_back(make_result(tofs_pkg::KIND_REFUSE, 0, 0, 0,
                        tofs_pkg::ERR_EMPTY, 0));
                end else begin
                    for (i = 0; i < ndev; i++)
                        if (slot_mv[i] < reg_safety_min) break;
                    if (i < ndev) begin
                        res.push_back(make_result(tofs_pkg::KIND_REFUSE, 0, 0, 0,
                            tofs_pkg::ERR_LOW, 3'(i)));
                    end else begin
                        step_next = 0;
                        ms_count = '0;
                        is_playing = 1'b1;
                    end
                end
            end
            tofs_pkg::MODE_ABORT: begin
                is_playing = 1'b0;
                for (i = 0; i < ndev; i++)
                    for (j = 0; j < OUTPUTS_CAP; j++)
                        res.push_back(make_result(tofs_pkg::KIND_COIL, slot_addr[i],
                            reg_coil_base + 16'(j), 16'd0, tofs_pkg::ERR_NONE, 3'd0));
            end
            tofs_pkg::MODE_ADDR: begin
                if (c.device_index < DEVICES_CAP) slot_addr[c.device_index] = c.device_addr;
            end
            tofs_pkg::MODE_SAFETY: begin
                if (c.device_index < DEVICES_CAP) slot_mv[c.device_index] = c.safety_mv;
            end
            default: begin
                for (i = 0; i < ndev; i++)
                    res.push_back(make_result(tofs_pkg::KIND_REG, slot_addr[i], 16'd0,
                        c.enter_flag ? reg_enter : reg_exit, tofs_pkg::ERR_NONE, 3'd0));
            end
        endcase
        if (res.size() == 0)
            res.push_back(make_result(tofs_pkg::KIND_STATUS, 0, 0, 0, tofs_pkg::ERR_NONE, 0));
        foreach (res[k]) begin
            res[k].running = is_playing;
            res[k].step_index = 6'(step_next);
            res[k].seq_length = 6'(steps_held);
            res[k].last = (k == res.size() - 1);
            expected_writes.push_back(res[k]);
        end
    endtask

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic cmd_item_t rand_cmd(logic [2:0] m);
        cmd_item_t c;
        c.mode = m;
        c.device_index = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
        c.output_number = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
        c.wait_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        c.device_addr = 8'($urandom);
        c.safety_mv = 16'($urandom);
        c.enter_flag = 1'($urandom);
        return c;
    endfunction

    function automatic cmd_item_t make_cmd(logic [2:0] m, logic [7:0] dix, logic [7:0] outn,
            logic [15:0] dly, logic [7:0] addr, logic [15:0] mv, logic ent);
        cmd_item_t c;
        c.mode = m;
        c.device_index = dix;
        c.output_number = outn;
        c.wait_ms = dly;
        c.device_addr = addr;
        c.safety_mv = mv;
        c.enter_flag = ent;
        return c;
    endfunction

    // Driver: one item per handshake, random gaps between items.
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            gap_left <= 0;
        end else if (!(i_start && o_busy)) begin
            if (i_start) predict_fire_results({i_mode, i_device_index, i_output_number,
                i_wait_ms, i_device_addr, i_safety_mv, i_enter_flag});
            if (gap_left > 0 || pending_cmds.size() == 0) begin
                i_start <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                cmd_item_t c;
                c = pending_cmds.pop_front();
                i_start <= 1'b1;
                {i_mode, i_device_index, i_output_number, i_wait_ms, i_device_addr,
                    i_safety_mv, i_enter_flag} <= c;
                gap_left <= gap_length();
            end
        end
    end

    // Register writes are handed over by the sequence below and applied here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            i_cfg_valid <= 1'b0;
            case (i_cfg_index)
                tofs_pkg::CFG_DEV_COUNT: reg_dev_count = i_cfg_data[3:0];
                tofs_pkg::CFG_COIL_BASE: reg_coil_base = i_cfg_data;
                tofs_pkg::CFG_SAFETY:    reg_safety_min = i_cfg_data;
                tofs_pkg::CFG_ENTER:     reg_enter = i_cfg_data;
                tofs_pkg::CFG_EXIT:      reg_exit = i_cfg_data;
                default: ;
            endcase
            cfg_req = 1'b0;
        end else if (cfg_req && !i_cfg_valid) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= cfg_idx_req;
            i_cfg_data <= cfg_data_req;
        end
    end

    // Monitor: compare each result with the oldest expectation, and end the run past the stall limit.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_valid) begin
                fire_result_t got;
                fire_result_t want;
                got = {o_kind, o_bus_addr, o_target, o_value, o_error_code,
                    o_blocked_device, o_running, o_step_index, o_seq_length, o_last};
                if (expected_writes.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, got);
                    errors++;
                end else begin
                    want = expected_writes.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %h actual %h", $time, want, got);
                        errors++;
                    end
                end
            end
            if (idle_cycles > STALL_LIMIT) begin
                $display("FAIL timed_output_fire_sequencer_core");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || i_start || expected_writes.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        cfg_idx_req = idx;
        cfg_data_req = data;
        cfg_req = 1'b1;
        while (cfg_req) @(posedge i_clk);
    endtask

    // Mostly well-formed sequences: load, report safe levels, fire, tick it out.
    task automatic queue_random_phase(int count);
        int n;
        int k;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 3) != 0) begin
                pending_cmds.push_back(make_cmd(tofs_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0));
                k = $urandom_range(1, 6);
                if ($urandom_range(0, 7) == 0) k = 34;
                repeat (k) pending_cmds.push_back(rand_cmd(tofs_pkg::MODE_APPEND));
                if ($urandom_range(0, 2) != 0)
                    for (int d = 0; d < DEVICES_CAP; d++)
                        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_SAFETY, 8'(d), 0, 0, 0,
                            ($urandom_range(0, 7) == 0) ? 16'd0 : 16'hFFFF, 0));
                pending_cmds.push_back(rand_cmd(tofs_pkg::MODE_FIRE));
                repeat ($urandom_range(2, 10))
                    pending_cmds.push_back(rand_cmd(tofs_pkg::MODE_TICK));
                if ($urandom_range(0, 3) == 0)
                    pending_cmds.push_back(rand_cmd(tofs_pkg::MODE_APPEND));
                n += k + 4;
            end else begin
                pending_cmds.push_back(rand_cmd(3'($urandom)));
                n++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        {i_mode, i_device_index, i_output_number, i_wait_ms, i_device_addr,
            i_safety_mv, i_enter_flag} = '0;
        errors = 0;
        idle_cycles = 0;
        cfg_req = 1'b0;
        steps_held = 0;
        step_next = 0;
        is_playing = 1'b0;
        ms_count = '0;
        reg_dev_count = '0;
        reg_coil_base = '0;
        reg_safety_min = '0;
        reg_enter = '0;
        reg_exit = '0;
        for (int d = 0; d < DEVICES_CAP; d++) begin
            slot_addr[d] = '0;
            slot_mv[d] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, no devices, then extremes.
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_FIRE, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_ABORT, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_CMD, 0, 0, 0, 0, 0, 1));
        wait_idle();
        write_reg(tofs_pkg::CFG_DEV_COUNT, 16'hF);
        write_reg(tofs_pkg::CFG_COIL_BASE, 16'hFFFC);
        write_reg(tofs_pkg::CFG_SAFETY, 16'h8000);
        write_reg(tofs_pkg::CFG_ENTER, 16'hFFFF);
        write_reg(tofs_pkg::CFG_EXIT, 16'h0);
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_ADDR, 8'd7, 0, 0, 8'hFF, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_ADDR, 8'hFF, 0, 0, 8'h55, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_SAFETY, 8'hFF, 0, 0, 0, 16'hFFFF, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_APPEND, 8'd7, 8'd8, 16'd0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_APPEND, 8'd200, 8'd0, 16'd0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_APPEND, 8'd3, 8'hFF, 16'd2, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_FIRE, 0, 0, 0, 0, 0, 0));
        for (int d = 0; d < DEVICES_CAP; d++)
            pending_cmds.push_back(make_cmd(tofs_pkg::MODE_SAFETY, 8'(d), 0, 0, 0, 16'hFFFF, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_FIRE, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_CMD, 0, 0, 0, 0, 0, 1));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_CMD, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_ABORT, 0, 0, 0, 0, 0, 0));
        wait_idle();

        // A long wait: one large delay that outlasts the ticks sent.
        write_reg(tofs_pkg::CFG_SAFETY, 16'h0);
        write_reg(tofs_pkg::CFG_DEV_COUNT, 16'd1);
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_APPEND, 0, 8'd1, 16'hFFFF, 0, 0, 0));
        pending_cmds.push_back(make_cmd(tofs_pkg::MODE_FIRE, 0, 0, 0, 0, 0, 0));
        wait_idle();
        repeat (4) pending_cmds.push_back(make_cmd(tofs_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0));
        wait_idle();

        // Random phases under several register settings.
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(tofs_pkg::CFG_DEV_COUNT, 16'($urandom_range(0, 15)));
            write_reg(tofs_pkg::CFG_COIL_BASE, (ph == 4) ? 16'hFFFF : 16'($urandom));
            write_reg(tofs_pkg::CFG_SAFETY, (ph == 4) ? 16'hFFFF : 16'($urandom));
            write_reg(tofs_pkg::CFG_ENTER, 16'($urandom));
            write_reg(tofs_pkg::CFG_EXIT, 16'($urandom));
            for (int d = 0; d < DEVICES_CAP; d++)
                pending_cmds.push_back(make_cmd(tofs_pkg::MODE_ADDR, 8'(d), 0, 0,
                    8'($urandom), 0, 0));
            queue_random_phase(22);
            wait_idle();
        end

        if (errors == 0)
            $display("PASS timed_output_fire_sequencer_core");
        else
            $display("FAIL timed_output_fire_sequencer_core");
        $finish;
    end
endmodule
